>>> src/imh_pkg.sv
// Package for the indexed min-heap: request and status codes, entry type.
// No dependencies.
`timescale 1ns / 1ps
package imh_pkg;
  localparam int KeyW  = 10;
  localparam int CostW = 24;
  localparam int PayW  = 16;

  typedef enum logic [2:0] {
    REQ_PUSH = 3'd0, REQ_POP = 3'd1, REQ_DEC = 3'd2, REQ_LOOKUP = 3'd3, REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_FULL = 3'd2, ST_NOTFOUND = 3'd3,
    ST_LARGER = 3'd4, ST_DUP = 3'd5
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [CostW-1:0] cost;
    logic [PayW-1:0]  pay;
  } entry_t;
endpackage

>>> src/imh_if.sv
// Valid/ready channel interfaces for the indexed min-heap.
// Depends on imh_pkg.
`timescale 1ns / 1ps
interface imh_req_if import imh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       req_type;
  logic [KeyW-1:0]  key_id;
  logic [CostW-1:0] cost;
  logic [PayW-1:0]  payload;
  modport source (output valid, req_type, key_id, cost, payload, input ready);
  modport sink   (input valid, req_type, key_id, cost, payload, output ready);
endinterface

interface imh_rsp_if import imh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [KeyW-1:0]  item_key;
  logic [CostW-1:0] item_cost;
  logic [PayW-1:0]  item_payload;
  logic [7:0]       item_slot;
  logic [8:0]       fill_count;
  modport source (output valid, status, item_key, item_cost, item_payload, item_slot,
                  fill_count, input ready);
  modport sink   (input valid, status, item_key, item_cost, item_payload, item_slot,
                  fill_count, output ready);
endinterface

>>> src/imh_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module imh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/indexed_min_heap.sv
// Top level of the indexed min-heap: sequencer around the heap and key tables.
// Depends on imh_pkg, imh_if and imh_ram.
`timescale 1ns / 1ps
// Indexed binary min-heap of up to HEAP_DEPTH items ordered by cost, with a
// key-to-slot table. One request is handled at a time. Each level moved up
// takes a read of the parent, then a compare and write; each level moved down
// takes a read of the left child, a read of the right child, then a compare
// and write. The heap memory has one read port, so these reads are made one
// after another. After reset and after a clear the key table is swept, one
// entry a cycle over all KEY_COUNT entries, while no request is taken. The
// result waits in an output register; the next request is taken once it has
// left. Keys at or above KEY_COUNT are reported as not found.
module indexed_min_heap import imh_pkg::*; #(
  parameter int HEAP_DEPTH = 256,
  parameter int KEY_COUNT  = 1024
) (
  input logic   clk_i,
  input logic   rst_ni,
  imh_req_if.sink   req_i,
  imh_rsp_if.source rsp_o
);
  localparam int SW = (HEAP_DEPTH > 2) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int KW = (KEY_COUNT > 2) ? $clog2(KEY_COUNT) : 1;
  localparam int TW = SW + 1;
  localparam int XW = SW + 2;

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_TRD = 4'd2, S_TCHK = 4'd3,
    S_HRD = 4'd4, S_HCHK = 4'd5, S_UPRD = 4'd6, S_UPCMP = 4'd7, S_DNL = 4'd8,
    S_DNR = 4'd9, S_DNCMP = 4'd10, S_POPL = 4'd11, S_DONE = 4'd12, S_POPL2 = 4'd13;

  logic [3:0] state_q, state_d;
  logic [KW-1:0] clr_q, clr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0] req_q, req_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [CostW-1:0] cost_q, cost_d;
  logic [PayW-1:0] pay_q, pay_d;
  entry_t cur_q, cur_d, lch_q, lch_d;
  logic [SW-1:0] i_q, i_d;
  logic rsp_v_q, rsp_v_d;
  logic [2:0] st_q, st_d;
  entry_t res_q, res_d;
  logic [7:0] rslot_q, rslot_d;

  // heap RAM
  logic h_we; logic [SW-1:0] h_wa, h_ra; entry_t h_wd, h_rd;
  // key table: valid bit and slot
  logic t_we; logic [KW-1:0] t_wa, t_ra; logic [TW-1:0] t_wd, t_rd;

  imh_ram #(.Width($bits(entry_t)), .Depth(HEAP_DEPTH)) u_heap (
    .clk_i, .we_i(h_we), .waddr_i(h_wa), .wdata_i(h_wd), .raddr_i(h_ra), .rdata_o(h_rd));
  imh_ram #(.Width(TW), .Depth(KEY_COUNT)) u_tab (
    .clk_i, .we_i(t_we), .waddr_i(t_wa), .wdata_i(t_wd), .raddr_i(t_ra), .rdata_o(t_rd));

  logic kin;
  logic [SW-1:0] par, lc, rc;
  logic [XW-1:0] lc_w, rc_w, cnt_x;
  assign kin   = ({{(KW+KeyW){1'b0}}, key_q} < (KW+KeyW+KeyW)'(KEY_COUNT));
  assign par   = SW'((i_q - 1'b1) >> 1);
  assign lc_w  = {1'b0, i_q, 1'b1};
  assign rc_w  = lc_w + XW'(1);
  assign cnt_x = XW'(cnt_q);
  assign lc    = lc_w[SW-1:0];
  assign rc    = rc_w[SW-1:0];

  always_comb begin
    state_d = state_q; clr_d = clr_q; cnt_d = cnt_q; req_d = req_q;
    key_d = key_q; cost_d = cost_q; pay_d = pay_q; cur_d = cur_q; lch_d = lch_q;
    i_d = i_q; rsp_v_d = rsp_v_q; st_d = st_q; res_d = res_q;
    rslot_d = rslot_q;
    h_we = 1'b0; h_wa = i_q; h_wd = cur_q; h_ra = i_q;
    t_we = 1'b0; t_wa = KW'(key_q); t_wd = {1'b1, i_q}; t_ra = KW'(key_q);
    req_i.ready = 1'b0;
    if (rsp_o.valid && rsp_o.ready) rsp_v_d = 1'b0;
    unique case (state_q)
      S_CLR: begin
        t_we = 1'b1; t_wa = clr_q; t_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == KW'(KEY_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_i.ready = !rsp_v_q;
        if (req_i.valid && !rsp_v_q) begin
          req_d = req_i.req_type; key_d = req_i.key_id;
          cost_d = req_i.cost; pay_d = req_i.payload;
          st_d = ST_OK; res_d = '0; rslot_d = '0;
          t_ra = KW'(req_i.key_id);
          h_ra = '0;
          unique case (req_i.req_type) inside
            REQ_PUSH, REQ_DEC, REQ_LOOKUP: state_d = S_TCHK;
            REQ_POP: begin
              if (cnt_q == '0) begin st_d = ST_EMPTY; state_d = S_DONE; end
              else state_d = S_POPL;
            end
            REQ_CLEAR: begin cnt_d = '0; clr_d = '0; state_d = S_CLR; rsp_v_d = 1'b1; end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_TCHK: begin
        i_d = t_rd[SW-1:0];
        if (!kin) begin st_d = ST_NOTFOUND; state_d = S_DONE; end
        else if (req_q == REQ_PUSH) begin
          if (t_rd[TW-1]) begin st_d = ST_DUP; state_d = S_DONE; end
          else if (cnt_q >= CW'(HEAP_DEPTH)) begin st_d = ST_FULL; state_d = S_DONE; end
          else begin
            i_d = SW'(cnt_q); cnt_d = cnt_q + 1'b1;
            cur_d = '{key: key_q, cost: cost_q, pay: pay_q};
            state_d = S_UPRD;
          end
        end else if (!t_rd[TW-1]) begin st_d = ST_NOTFOUND; state_d = S_DONE; end
        else begin h_ra = t_rd[SW-1:0]; state_d = S_HCHK; end
      end
      S_HCHK: begin
        if (req_q == REQ_LOOKUP) begin
          res_d = h_rd; rslot_d = 8'(i_q); state_d = S_DONE;
        end else if (cost_q > h_rd.cost) begin st_d = ST_LARGER; state_d = S_DONE; end
        else begin
          cur_d = '{key: h_rd.key, cost: cost_q, pay: pay_q};
          state_d = S_UPRD;
        end
      end
      S_UPRD: begin
        // read parent, or settle at the root
        if (i_q == '0) begin
          h_we = 1'b1; t_we = 1'b1; t_wa = KW'(cur_q.key); state_d = S_DONE;
        end else begin h_ra = par; state_d = S_UPCMP; end
      end
      S_UPCMP: begin
        if (cur_q.cost < h_rd.cost) begin
          // move parent down into this slot
          h_we = 1'b1; h_wd = h_rd; t_we = 1'b1; t_wa = KW'(h_rd.key); t_wd = {1'b1, i_q};
          i_d = par; state_d = S_UPRD;
        end else begin
          h_we = 1'b1; t_we = 1'b1; t_wa = KW'(cur_q.key); state_d = S_DONE;
        end
      end
      S_POPL: begin
        res_d = h_rd; h_ra = SW'(cnt_q - 1'b1); state_d = S_POPL2;
        t_we = 1'b1; t_wa = KW'(h_rd.key); t_wd = '0;
      end
      S_POPL2: begin
        cnt_d = cnt_q - 1'b1; cur_d = h_rd; i_d = '0;
        if (cnt_q == CW'(1)) state_d = S_DONE;
        else state_d = S_DNL;
        h_ra = SW'(1);
      end
      S_DNL: begin
        // left child read issued last cycle; issue right
        lch_d = h_rd; h_ra = rc;
        if (!(lc_w < cnt_x)) begin
          h_we = 1'b1; t_we = 1'b1; t_wa = KW'(cur_q.key); state_d = S_DONE;
        end else state_d = S_DNR;
      end
      S_DNR: begin
        // hold the right child address so its data is there for the compare
        h_ra = rc; state_d = S_DNCMP;
      end
      S_DNCMP: begin
        if ((rc_w < cnt_x) && (h_rd.cost < lch_q.cost) && (h_rd.cost < cur_q.cost)) begin
          h_we = 1'b1; h_wd = h_rd; t_we = 1'b1; t_wa = KW'(h_rd.key); t_wd = {1'b1, i_q};
          i_d = rc; h_ra = SW'({rc, 1'b1}); state_d = S_DNL;
        end else if (lch_q.cost < cur_q.cost) begin
          h_we = 1'b1; h_wd = lch_q; t_we = 1'b1; t_wa = KW'(lch_q.key); t_wd = {1'b1, i_q};
          i_d = lc; h_ra = SW'({lc, 1'b1}); state_d = S_DNL;
        end else begin
          h_we = 1'b1; t_we = 1'b1; t_wa = KW'(cur_q.key); state_d = S_DONE;
        end
      end
      S_DONE: begin rsp_v_d = 1'b1; state_d = S_IDLE; end
      default: state_d = S_IDLE;
    endcase
  end

  // a child index past the memory wraps; the count compare keeps it unused
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; cnt_q <= '0; rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; cnt_q <= cnt_d; rsp_v_q <= rsp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; key_q <= key_d; cost_q <= cost_d; pay_q <= pay_d;
    cur_q <= cur_d; lch_q <= lch_d; i_q <= i_d;
    st_q <= st_d; res_q <= res_d; rslot_q <= rslot_d;
  end

  assign rsp_o.valid        = rsp_v_q;
  assign rsp_o.status       = st_q;
  assign rsp_o.item_key     = res_q.key;
  assign rsp_o.item_cost    = res_q.cost;
  assign rsp_o.item_payload = res_q.pay;
  assign rsp_o.item_slot    = rslot_q;
  assign rsp_o.fill_count   = 9'(cnt_q);
endmodule

>>> src/imh_checker.sv
// Port-level checks for the indexed min-heap, bound to the top level.
// Depends on imh_pkg.
`timescale 1ns / 1ps
module imh_checker import imh_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       req_ready,
  input logic [2:0] status,
  input logic [8:0] fill_count
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)) else $error("result dropped");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("request taken while result waits");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> status <= 3'd5) else $error("bad status");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && status == ST_EMPTY |-> fill_count == 9'd0) else $error("empty with items");
endmodule

bind indexed_min_heap imh_checker u_chk (
  .clk_i, .rst_ni, .rsp_valid(rsp_o.valid), .rsp_ready(rsp_o.ready),
  .req_ready(req_i.ready), .status(rsp_o.status), .fill_count(rsp_o.fill_count));
